// ----- rtl/rkt_pkg.sv -----
// Shared types, codes and defaults for the recent key table.
`default_nettype none
package rkt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 32;
  localparam int unsigned DEF_KEY_BITS    = 64;
  localparam int unsigned DEF_TIME_BITS   = 32;

  localparam int unsigned NOW_BITS   = 32;
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned CAP_BITS   = 6;
  localparam int unsigned COUNT_BITS = 6;
  localparam int unsigned ORDER_BITS = 16;

  // register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_EXPIRY   = 1'b1;

  localparam logic [CAP_BITS-1:0] CAP_RESET    = 6'd32;
  localparam logic [CFG_BITS-1:0] EXPIRY_RESET = 32'd10000;

  // request actions
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SWEEP  = 2'd2;
  localparam logic [1:0] ACT_FETCH  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_CLEARED   = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_SWEPT     = 3'd6;
  localparam logic [2:0] ST_ENTRY     = 3'd7;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR_ALL,
    CMD_REFRESH,
    CMD_VICTIM_STEP,
    CMD_EVICT,
    CMD_PLACE,
    CMD_REMOVE,
    CMD_SWEEP_STEP,
    CMD_SWEEP_DONE,
    CMD_FETCH_START,
    CMD_FETCH_STEP,
    CMD_FETCH_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic wd_trip;
    logic hit;
    logic empty;
    logic scan_last;
    logic last_pick;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/rkt_ctrl.sv -----
// Sequencer for the recent key table: walks each request through its steps.
`default_nettype none
module rkt_ctrl
  import rkt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic [1:0] action_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_e       cmd_o,
  output logic          busy_o
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_ADD_CHK    = 4'd1;
  localparam logic [3:0] S_VICTIM     = 4'd2;
  localparam logic [3:0] S_EVICT      = 4'd3;
  localparam logic [3:0] S_PLACE      = 4'd4;
  localparam logic [3:0] S_REMOVE     = 4'd5;
  localparam logic [3:0] S_SWEEP      = 4'd6;
  localparam logic [3:0] S_SWEEP_DONE = 4'd7;
  localparam logic [3:0] S_FETCH_CHK  = 4'd8;
  localparam logic [3:0] S_FETCH_SCAN = 4'd9;
  localparam logic [3:0] S_FETCH_EMIT = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o = CMD_LOAD;
          case (action_i)
            ACT_ADD:    state_d = S_ADD_CHK;
            ACT_REMOVE: state_d = S_REMOVE;
            ACT_SWEEP:  state_d = S_SWEEP;
            default:    state_d = S_FETCH_CHK;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (stat_i.wd_trip) begin
          cmd_o   = CMD_CLEAR_ALL;
          state_d = S_IDLE;
        end else if (stat_i.hit) begin
          cmd_o   = CMD_REFRESH;
          state_d = S_IDLE;
        end else begin
          state_d = S_VICTIM;
        end
      end
      S_VICTIM: begin
        cmd_o = CMD_VICTIM_STEP;
        if (stat_i.scan_last) state_d = S_EVICT;
      end
      S_EVICT: begin
        cmd_o   = CMD_EVICT;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        cmd_o   = CMD_PLACE;
        state_d = S_IDLE;
      end
      S_REMOVE: begin
        cmd_o   = CMD_REMOVE;
        state_d = S_IDLE;
      end
      S_SWEEP: begin
        cmd_o = CMD_SWEEP_STEP;
        if (stat_i.scan_last) state_d = S_SWEEP_DONE;
      end
      S_SWEEP_DONE: begin
        cmd_o   = CMD_SWEEP_DONE;
        state_d = S_IDLE;
      end
      S_FETCH_CHK: begin
        cmd_o   = CMD_FETCH_START;
        state_d = stat_i.empty ? S_IDLE : S_FETCH_SCAN;
      end
      S_FETCH_SCAN: begin
        cmd_o = CMD_FETCH_STEP;
        if (stat_i.scan_last) state_d = S_FETCH_EMIT;
      end
      S_FETCH_EMIT: begin
        cmd_o   = CMD_FETCH_EMIT;
        state_d = stat_i.last_pick ? S_IDLE : S_FETCH_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/rkt_datapath.sv -----
// Table storage, parallel key match, scan unit and result registers.
`default_nettype none
module rkt_datapath
  import rkt_pkg::*;
#(
  parameter int unsigned DEPTH     = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS  = DEF_KEY_BITS,
  parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [CFG_BITS-1:0]  cfg_wdata_i,
  input  wire logic [KEY_BITS-1:0]  key_i,
  input  wire logic [NOW_BITS-1:0]  now_time_i,
  input  wire dp_cmd_e              cmd_i,
  output dp_stat_t                  stat_o,
  output logic                      result_valid_o,
  output logic [2:0]                status_o,
  output logic [KEY_BITS-1:0]       key_out_o,
  output logic [COUNT_BITS-1:0]     removed_count_o,
  output logic                      entry_valid_o,
  output logic                      last_result_o
);

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CW   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // table rows
  logic [KEY_BITS-1:0]   key_q   [DEPTH];
  logic [TIME_BITS-1:0]  time_q  [DEPTH];
  logic [ORDER_BITS-1:0] order_q [DEPTH];
  logic [DEPTH-1:0]      valid_q;
  logic [DEPTH-1:0]      listed_q;

  logic [ORDER_BITS-1:0] ctr_q;
  logic [TIME_BITS-1:0]  last_fetch_q;
  logic [CAP_BITS-1:0]   cap_q;
  logic [CFG_BITS-1:0]   exp_q;

  // request operands
  logic [KEY_BITS-1:0]  op_key_q;
  logic [TIME_BITS-1:0] op_now_q;

  // scan unit
  logic [IW-1:0]         idx_q;
  logic                  have_q;
  logic [IW-1:0]         best_idx_q;
  logic [TIME_BITS-1:0]  best_age_q;
  logic [ORDER_BITS-1:0] best_dist_q;
  logic [KEY_BITS-1:0]   best_key_q;
  logic [FW-1:0]         fill_q;
  logic [COUNT_BITS-1:0] sweep_cnt_q;
  logic                  did_evict_q;
  logic [KEY_BITS-1:0]   evict_key_q;

  // result registers
  logic                  res_valid_q;
  logic [2:0]            res_status_q;
  logic [KEY_BITS-1:0]   res_key_q;
  logic [COUNT_BITS-1:0] res_cnt_q;
  logic                  res_ev_q;
  logic                  res_last_q;

  // parallel match and free slot search
  logic [DEPTH-1:0] match;
  logic [IW-1:0]    hit_idx;
  logic             free_any;
  logic [IW-1:0]    free_idx;

  always_comb begin
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (key_q[i] == op_key_q);
      if (match[i]) hit_idx = IW'(i);
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // current scan entry
  logic [TIME_BITS-1:0]  age;
  logic [ORDER_BITS-1:0] order_gap;
  logic                  scan_valid;
  logic                  age_expired;
  logic                  victim_better;
  logic                  fetch_better;
  logic [TIME_BITS-1:0]  wd_age;
  logic [DEPTH-1:0]      remain;
  logic [CAP_BITS:0]     eff_cap;

  always_comb begin
    age           = op_now_q - time_q[idx_q];
    order_gap     = ctr_q - order_q[idx_q];
    scan_valid    = valid_q[idx_q];
    age_expired   = CW'(age) > CW'(exp_q);
    victim_better = !have_q || (age > best_age_q) ||
                    ((age == best_age_q) && (order_gap > best_dist_q));
    fetch_better  = !have_q || (key_q[idx_q] < best_key_q);
    wd_age        = op_now_q - last_fetch_q;
    remain        = valid_q & ~listed_q;
    remain[best_idx_q] = 1'b0;
    if (cap_q == '0) begin
      eff_cap = (CAP_BITS + 1)'(1);
    end else if ((CAP_BITS + 1)'(cap_q) > (CAP_BITS + 1)'(DEPTH)) begin
      eff_cap = (CAP_BITS + 1)'(DEPTH);
    end else begin
      eff_cap = (CAP_BITS + 1)'(cap_q);
    end
  end

  assign stat_o.wd_trip   = CW'(wd_age) > CW'(exp_q);
  assign stat_o.hit       = |match;
  assign stat_o.empty     = ~|valid_q;
  assign stat_o.scan_last = (idx_q == LAST_IDX);
  assign stat_o.last_pick = ~|remain;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      ctr_q        <= '0;
      last_fetch_q <= '0;
      cap_q        <= CAP_RESET;
      exp_q        <= EXPIRY_RESET;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_CAPACITY) begin
          cap_q <= cfg_wdata_i[CAP_BITS-1:0];
        end else begin
          exp_q <= cfg_wdata_i;
        end
      end
      case (cmd_i)
        CMD_CLEAR_ALL: begin
          valid_q     <= '0;
          res_valid_q <= 1'b1;
        end
        CMD_REFRESH: begin
          ctr_q       <= ctr_q + 1'b1;
          res_valid_q <= 1'b1;
        end
        CMD_EVICT: begin
          if (((CAP_BITS + 1)'(fill_q) >= eff_cap) && have_q) begin
            valid_q[best_idx_q] <= 1'b0;
          end
        end
        CMD_PLACE: begin
          if (free_any) begin
            valid_q[free_idx] <= 1'b1;
            ctr_q             <= ctr_q + 1'b1;
          end
          res_valid_q <= 1'b1;
        end
        CMD_REMOVE: begin
          if (|match) valid_q[hit_idx] <= 1'b0;
          res_valid_q <= 1'b1;
        end
        CMD_SWEEP_STEP: begin
          if (scan_valid && age_expired) valid_q[idx_q] <= 1'b0;
        end
        CMD_SWEEP_DONE: res_valid_q <= 1'b1;
        CMD_FETCH_START: begin
          last_fetch_q <= op_now_q;
          if (~|valid_q) res_valid_q <= 1'b1;
        end
        CMD_FETCH_EMIT: res_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload: table rows, operands, scan registers, result fields
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_key_q    <= key_i;
        op_now_q    <= TIME_BITS'(now_time_i);
        idx_q       <= '0;
        have_q      <= 1'b0;
        fill_q      <= '0;
        sweep_cnt_q <= '0;
        listed_q    <= '0;
      end
      CMD_CLEAR_ALL: begin
        res_status_q <= ST_CLEARED;
        res_key_q    <= '0;
        res_cnt_q    <= '0;
        res_ev_q     <= 1'b0;
        res_last_q   <= 1'b1;
      end
      CMD_REFRESH: begin
        time_q[hit_idx]  <= op_now_q;
        order_q[hit_idx] <= ctr_q;
        res_status_q     <= ST_REFRESHED;
        res_key_q        <= '0;
        res_cnt_q        <= '0;
        res_ev_q         <= 1'b0;
        res_last_q       <= 1'b1;
      end
      CMD_VICTIM_STEP: begin
        idx_q <= idx_q + 1'b1;
        if (scan_valid) begin
          fill_q <= fill_q + 1'b1;
          if (victim_better) begin
            have_q      <= 1'b1;
            best_idx_q  <= idx_q;
            best_age_q  <= age;
            best_dist_q <= order_gap;
          end
        end
      end
      CMD_EVICT: begin
        did_evict_q <= ((CAP_BITS + 1)'(fill_q) >= eff_cap) && have_q;
        evict_key_q <= key_q[best_idx_q];
      end
      CMD_PLACE: begin
        if (free_any) begin
          key_q[free_idx]   <= op_key_q;
          time_q[free_idx]  <= op_now_q;
          order_q[free_idx] <= ctr_q;
        end
        res_status_q <= did_evict_q ? ST_EVICTED : ST_ADDED;
        res_key_q    <= did_evict_q ? evict_key_q : '0;
        res_cnt_q    <= '0;
        res_ev_q     <= did_evict_q;
        res_last_q   <= 1'b1;
      end
      CMD_REMOVE: begin
        res_status_q <= (|match) ? ST_REMOVED : ST_NOT_FOUND;
        res_key_q    <= '0;
        res_cnt_q    <= '0;
        res_ev_q     <= 1'b0;
        res_last_q   <= 1'b1;
      end
      CMD_SWEEP_STEP: begin
        idx_q <= idx_q + 1'b1;
        if (scan_valid && age_expired && (sweep_cnt_q != COUNT_MAX)) begin
          sweep_cnt_q <= sweep_cnt_q + 1'b1;
        end
      end
      CMD_SWEEP_DONE: begin
        res_status_q <= ST_SWEPT;
        res_key_q    <= '0;
        res_cnt_q    <= sweep_cnt_q;
        res_ev_q     <= 1'b0;
        res_last_q   <= 1'b1;
      end
      CMD_FETCH_START: begin
        res_status_q <= ST_ENTRY;
        res_key_q    <= '0;
        res_cnt_q    <= '0;
        res_ev_q     <= 1'b0;
        res_last_q   <= 1'b1;
      end
      CMD_FETCH_STEP: begin
        idx_q <= idx_q + 1'b1;
        if (scan_valid && !listed_q[idx_q] && fetch_better) begin
          have_q     <= 1'b1;
          best_idx_q <= idx_q;
          best_key_q <= key_q[idx_q];
        end
      end
      CMD_FETCH_EMIT: begin
        listed_q[best_idx_q] <= 1'b1;
        idx_q        <= '0;
        have_q       <= 1'b0;
        res_status_q <= ST_ENTRY;
        res_key_q    <= best_key_q;
        res_cnt_q    <= '0;
        res_ev_q     <= 1'b1;
        res_last_q   <= ~|remain;
      end
      default: ;
    endcase
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign key_out_o       = res_key_q;
  assign removed_count_o = res_cnt_q;
  assign entry_valid_o   = res_ev_q;
  assign last_result_o   = res_last_q;

endmodule
`default_nettype wire

// ----- rtl/recent_key_table_lru_expiry.sv -----
// Top level of the recent key table with LRU eviction and time expiry.
//
// Issue a request by holding start_i high while busy_o is low; the request
// is taken at that clock edge. Each result appears for exactly one cycle with
// result_valid_o high and must be captured then, as the block never waits for
// the receiver. last_result_o marks the final result of a request. A remove,
// and an add that refreshes a held key, are decided by the parallel key
// compare across every row; an add that trips the watchdog, when the time
// since the last fetch exceeds the expiry interval, clears the whole table.
// An add of a new key runs the one-row-per-cycle victim scan, then the evict
// and place steps. A sweep runs through the same row scan. A fetch lists the
// held keys in ascending order by a fresh scan of all rows per listed key,
// with each key shown as its own result. busy_o drops in the cycle the last
// result is shown, so a new request may follow at once.
// Write capacity and expiry_interval through cfg_we_i/cfg_index_i/
// cfg_wdata_i only while the block is idle.
`default_nettype none
module recent_key_table_lru_expiry
  import rkt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS,
  parameter int unsigned TIME_BITS   = DEF_TIME_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_BITS-1:0]   cfg_wdata_i,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire logic [NOW_BITS-1:0]   now_time_i,
  output logic                       result_valid_o,
  output logic [2:0]                 status_o,
  output logic [KEY_BITS-1:0]        key_out_o,
  output logic [COUNT_BITS-1:0]      removed_count_o,
  output logic                       entry_valid_o,
  output logic                       last_result_o
);

  dp_cmd_e  cmd;
  dp_stat_t stat;

  // sequence each request
  rkt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // hold the table and produce results
  rkt_datapath #(
    .DEPTH     (TABLE_DEPTH),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .key_i           (key_i),
    .now_time_i      (now_time_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .key_out_o       (key_out_o),
    .removed_count_o (removed_count_o),
    .entry_valid_o   (entry_valid_o),
    .last_result_o   (last_result_o)
  );

endmodule
`default_nettype wire
